// ----- sv/assert_macros.svh -----
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define P2H_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define P2H_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define P2H_ASSERT(label, clk, rst, prop)
`define P2H_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- sv/p2h_pkg.sv -----
`timescale 1ns / 1ps
package p2h_pkg;

  localparam int PIX_W = 16;
  localparam int CELL_W = 16;
  localparam int INV_W = 25;
  localparam int CFG_INDEX_W = 8;

  // q0.24 constants
  localparam int K_W = 24;
  localparam logic [K_W-1:0] K_SQRT3_OVER_3 = 24'd9686330;
  localparam logic [K_W-1:0] K_ONE_THIRD = 24'd5592405;
  localparam logic [K_W-1:0] K_TWO_THIRDS = 24'd11184811;
  localparam logic [INV_W-1:0] INV_MAX = 25'h1000000;

  // pixel times constant, and the split for the radius multiply
  localparam int PROD_W = PIX_W + K_W + 1;
  localparam int SPLIT = 20;
  localparam int PL_W = SPLIT + INV_W;
  localparam int PH_W = PROD_W - SPLIT + INV_W + 1;
  localparam int FULL_W = 64;
  localparam int FULL_Q = 48;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LAYOUT_FLAT_TOP = 8'd0,
    REG_INVERSE_RADIUS  = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] cell_q;
    logic signed [CELL_W-1:0] cell_r;
  } cell_t;

endpackage

// ----- sv/p2h_round.sv -----
`timescale 1ns / 1ps
module p2h_round #(
  parameter int FRACTION_BITS = 16,
  parameter int IN_W = 33
) (
  input  logic signed [IN_W-1:0]          value,
  output logic signed [IN_W-FRACTION_BITS:0] rounded,
  output logic [FRACTION_BITS-1:0]        error
);

  localparam int MW = IN_W + 1;
  localparam int UW = IN_W - FRACTION_BITS + 1;

  logic                     neg;
  logic [MW-1:0]            mag;
  logic [FRACTION_BITS-1:0] frac;
  logic [UW-1:0]            up_mag;

  // half away from zero on the magnitude, error is distance to the chosen integer
  always_comb begin
    neg = value[IN_W-1];
    mag = neg ? -MW'(value) : MW'(value);
    frac = mag[FRACTION_BITS-1:0];
    up_mag = mag[MW-1:FRACTION_BITS] + UW'(frac[FRACTION_BITS-1]);
    rounded = neg ? -$signed(up_mag) : $signed(up_mag);
    error = frac[FRACTION_BITS-1] ? -frac : frac;
  end

endmodule

// ----- sv/pixel_to_hex_cell_core.sv -----
`timescale 1ns / 1ps
// pixel position to axial hex cell (q, r), pointy-top or flat-top layout
// pixel channel: pixel_valid / pixel_ready with a pixel_t request (x, y)
// cell channel: cell_valid / cell_ready with a cell_t request (q, r), saturated
// cfg channel: cfg_valid / cfg_ready, cfg_index 0 = layout_flat_top,
//   1 = inverse_radius (q1.24, values above 1.0 act as 1.0), other indexes ignored;
//   cfg_ready is always high, write only while no request is in flight
// seven register stages: constant multiply, axial sum, split radius multiply,
//   partial product sum and floor, third cube coordinate, rounding,
//   correction and saturation
// throughput: one request per cycle, limited by nothing but the cell channel
// when cell_ready is low the stages fill bubbles first; pixel_ready drops
//   only once every stage holds a request, nothing is lost or repeated
// reset (synchronous): clears the pipeline valids and loads layout pointy-top,
//   inverse_radius 1/16
`include "assert_macros.svh"
module pixel_to_hex_cell_core import p2h_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pixel_valid,
  output logic                   pixel_ready,
  input  pixel_t                 pixel,
  output logic                   cell_valid,
  input  logic                   cell_ready,
  output cell_t                  hex_cell,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [INV_W-1:0]       cfg_data
);

  localparam int NS = 7;
  localparam int S = FULL_Q - FRACTION_BITS;
  localparam int XW = FULL_W - S;
  localparam int ZW = XW + 1;
  localparam int RW = ZW - FRACTION_BITS + 1;
  localparam int EW = RW + 1;

  logic             layout_flat_top;
  logic [INV_W-1:0] inverse_radius;
  logic [INV_W-1:0] inv_sat;

  logic [NS:1] v;
  logic [NS:1] en;

  logic signed [PROD_W-1:0] m0, m1, m2, m3;
  logic signed [PROD_W-1:0] m0_next, m1_next, m2_next, m3_next;
  logic signed [PROD_W-1:0] aq, ar;
  logic [PL_W-1:0]          aq_lo, ar_lo;
  logic signed [PH_W-1:0]   aq_hi, ar_hi;
  logic signed [FULL_W-1:0] qa_full, qr_full;
  logic signed [XW-1:0]     fx4, fy4;
  logic signed [ZW-1:0]     fx5, fy5, fz5;
  logic signed [RW-1:0]     rx_next, ry_next, rz_next;
  logic [FRACTION_BITS-1:0] dx_next, dy_next, dz_next;
  logic signed [RW-1:0]     rx, ry, rz;
  logic [FRACTION_BITS-1:0] dx, dy, dz;
  logic signed [EW-1:0]     qx, qy;
  cell_t                    cell_next;

  function automatic logic signed [CELL_W-1:0] sat_cell(input logic signed [EW-1:0] val);
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] lo;
    hi = EW'(32767);
    lo = EW'(-32768);
    if (val > hi) begin
      sat_cell = CELL_W'(hi);
    end else if (val < lo) begin
      sat_cell = CELL_W'(lo);
    end else begin
      sat_cell = CELL_W'(val);
    end
  endfunction

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      layout_flat_top <= 1'b0;
      inverse_radius <= 25'd1048576;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LAYOUT_FLAT_TOP: layout_flat_top <= cfg_data[0];
        REG_INVERSE_RADIUS:  inverse_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  assign inv_sat = (inverse_radius > INV_MAX) ? INV_MAX : inverse_radius;

  // stage control, a stage moves when it is empty or the next one moves
  always_comb begin
    en[NS] = ~v[NS] | cell_ready;
    for (int i = NS - 1; i >= 1; i--) begin
      en[i] = ~v[i] | en[i+1];
    end
  end

  assign pixel_ready = en[1];
  assign cell_valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) begin
        v[1] <= pixel_valid;
      end
      for (int i = 2; i <= NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 1: pixel times constants
  always_comb begin
    m0_next = $signed(pixel.pixel_x)
            * $signed({1'b0, layout_flat_top ? K_TWO_THIRDS : K_SQRT3_OVER_3});
    m1_next = $signed(pixel.pixel_y) * $signed({1'b0, K_ONE_THIRD});
    m2_next = $signed(pixel.pixel_y)
            * $signed({1'b0, layout_flat_top ? K_SQRT3_OVER_3 : K_TWO_THIRDS});
    m3_next = $signed(pixel.pixel_x) * $signed({1'b0, K_ONE_THIRD});
    if (layout_flat_top) begin
      m1_next = '0;
    end else begin
      m3_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m0 <= m0_next;
      m1 <= m1_next;
      m2 <= m2_next;
      m3 <= m3_next;
    end
  end

  // stage 2: axial sums in q.24
  always_ff @(posedge clk) begin
    if (en[2]) begin
      aq <= m0 - m1;
      ar <= m2 - m3;
    end
  end

  // stage 3: split multiply by the inverse radius
  always_ff @(posedge clk) begin
    if (en[3]) begin
      aq_lo <= aq[SPLIT-1:0] * inv_sat;
      ar_lo <= ar[SPLIT-1:0] * inv_sat;
      aq_hi <= $signed(aq[PROD_W-1:SPLIT]) * $signed({1'b0, inv_sat});
      ar_hi <= $signed(ar[PROD_W-1:SPLIT]) * $signed({1'b0, inv_sat});
    end
  end

  // stage 4: join partial products, floor to the fraction format
  always_comb begin
    qa_full = (FULL_W'(aq_hi) <<< SPLIT) + FULL_W'(aq_lo);
    qr_full = (FULL_W'(ar_hi) <<< SPLIT) + FULL_W'(ar_lo);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      fx4 <= qa_full[FULL_W-1:S];
      fy4 <= qr_full[FULL_W-1:S];
    end
  end

  // stage 5: third cube coordinate
  always_ff @(posedge clk) begin
    if (en[5]) begin
      fx5 <= ZW'(fx4);
      fy5 <= ZW'(fy4);
      fz5 <= -ZW'(fx4) - ZW'(fy4);
    end
  end

  // stage 6: rounding and errors
  p2h_round #(.FRACTION_BITS(FRACTION_BITS), .IN_W(ZW)) u_round_x (
    .value(fx5), .rounded(rx_next), .error(dx_next)
  );
  p2h_round #(.FRACTION_BITS(FRACTION_BITS), .IN_W(ZW)) u_round_y (
    .value(fy5), .rounded(ry_next), .error(dy_next)
  );
  p2h_round #(.FRACTION_BITS(FRACTION_BITS), .IN_W(ZW)) u_round_z (
    .value(fz5), .rounded(rz_next), .error(dz_next)
  );

  always_ff @(posedge clk) begin
    if (en[6]) begin
      rx <= rx_next;
      ry <= ry_next;
      rz <= rz_next;
      dx <= dx_next;
      dy <= dy_next;
      dz <= dz_next;
    end
  end

  // stage 7: fix the coordinate with the largest error, saturate
  always_comb begin
    qx = EW'(rx);
    qy = EW'(ry);
    if (dx > dy && dx > dz) begin
      qx = -EW'(ry) - EW'(rz);
    end else if (dy > dz) begin
      qy = -EW'(rx) - EW'(rz);
    end
    cell_next.cell_q = sat_cell(qx);
    cell_next.cell_r = sat_cell(qy);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      hex_cell <= cell_next;
    end
  end

  `P2H_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !cell_valid)
  `P2H_ASSERT(a_accept_loads, clk, rst, pixel_valid && pixel_ready |=> v[1])
  `P2H_ASSERT(a_empty_out_ready, clk, rst, !cell_valid |-> pixel_ready)

endmodule
